// File: rtl/mdst_pkg.sv
// ----------------------------------------------------------------------------
// mdst_pkg
// Shared types and codes of the directory sharer tracker.
// ----------------------------------------------------------------------------
package mdst_pkg;

   localparam logic [2:0] OP_RD_SHARE = 3'd0;
   localparam logic [2:0] OP_RD_EXCL  = 3'd1;
   localparam logic [2:0] OP_WB_CLEAN = 3'd2;
   localparam logic [2:0] OP_WB_DIRTY = 3'd3;
   localparam logic [2:0] OP_FORWARD  = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;

   localparam logic [2:0] CST_I         = 3'd0;
   localparam logic [2:0] CST_S         = 3'd1;
   localparam logic [2:0] CST_E         = 3'd2;
   localparam logic [2:0] CST_M         = 3'd3;
   localparam logic [2:0] CST_UNCHANGED = 3'd4;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_INVAL     = 2'd1;
   localparam logic [1:0] KIND_DOWNGRADE = 2'd2;
   localparam logic [1:0] KIND_FORWARD   = 2'd3;

   localparam int FLAG_NO_EXCL   = 0;
   localparam int FLAG_KEEP_EXCL = 1;

   localparam logic [4:0] CHILDREN_RESET = 5'd16;

   typedef struct packed {
      logic [2:0]  op;
      logic [9:0]  entry_index;
      logic        entry_present;
      logic [3:0]  child_id;
      logic [1:0]  request_flags;
      logic        is_flush;
   } req_type;

   typedef struct packed {
      logic [2:0]  child_state;
      logic [15:0] inval_mask;
      logic [1:0]  inval_kind;
      logic        inval_flush;
      logic        evict_entry;
      logic        protocol_error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// File: rtl/mdst_engine.sv
// ----------------------------------------------------------------------------
// mdst_engine
// Next entry contents and result of one request, from the entry as read.
// ----------------------------------------------------------------------------
module mdst_engine #(
   parameter int SW       = 16,
   parameter int CHILDREN = 16,
   parameter int ENTRIES  = 1024
) (
   input  mdst_pkg::req_type req,
   input  logic [SW-1:0]     use_mask,
   input  logic [SW-1:0]     cur_bits,
   input  logic [4:0]        cur_count,
   input  logic              cur_excl,
   output logic              upd_we,
   output logic [SW-1:0]     upd_bits,
   output logic [4:0]        upd_count,
   output logic              upd_excl,
   output mdst_pkg::rsp_type rsp
);
   import mdst_pkg::*;

   always_comb begin
      logic [SW-1:0] b;
      logic [4:0]    c;
      logic          x;
      logic [SW-1:0] cbit;
      logic [SW-1:0] snd;
      logic [2:0]    st;
      logic [1:0]    kind;
      logic          fl;
      logic          ev;
      logic          err;
      logic          we;

      b    = cur_bits;
      c    = cur_count;
      x    = cur_excl;
      cbit = SW'(1) << req.child_id;
      snd  = '0;
      st   = CST_UNCHANGED;
      kind = KIND_NONE;
      fl   = 1'b0;
      ev   = 1'b0;
      err  = 1'b0;
      we   = 1'b0;

      priority if (int'(req.entry_index) >= ENTRIES) begin
         if (req.op <= OP_CLEAR) begin
            err = 1'b1;
         end
      end else if (req.op <= OP_WB_DIRTY && int'(req.child_id) >= CHILDREN) begin
         err = 1'b1;
      end else begin
         unique case (req.op)
            OP_RD_SHARE: begin
               we = 1'b1;
               if (!req.entry_present) begin
                  b = '0;
                  c = '0;
                  x = 1'b0;
               end
               if (c == 5'd0 && !req.request_flags[FLAG_NO_EXCL]) begin
                  x  = 1'b1;
                  b  = b | cbit;
                  c  = 5'd1;
                  st = CST_E;
               end else begin
                  if ((b & cbit) != '0) begin
                     err = 1'b1;
                  end
                  if (x && c == 5'd1) begin
                     snd = b & use_mask;
                     if (5'($countones(snd)) != c) begin
                        err = 1'b1;
                     end
                     if (snd != '0) begin
                        kind = KIND_DOWNGRADE;
                     end
                  end
                  b  = b | cbit;
                  c  = c + 5'd1;
                  x  = 1'b0;
                  st = CST_S;
               end
            end
            OP_RD_EXCL: begin
               we = 1'b1;
               if (!req.entry_present) begin
                  b = '0;
                  c = '0;
                  x = 1'b0;
               end
               if ((b & cbit) != '0) begin
                  if (x && c == 5'd1) begin
                     err = 1'b1;
                  end
                  b = b & ~cbit;
                  c = c - 5'd1;
               end
               if (c != 5'd0) begin
                  snd = b & use_mask;
                  if (5'($countones(snd)) != c) begin
                     err = 1'b1;
                  end
                  b = b & ~snd;
                  c = 5'd0;
                  if (snd != '0) begin
                     kind = KIND_INVAL;
                  end
               end
               b = b | cbit;
               c = c + 5'd1;
               x = 1'b1;
               if (c != 5'd1) begin
                  err = 1'b1;
               end
               st = CST_M;
            end
            OP_WB_CLEAN, OP_WB_DIRTY: begin
               if (req.entry_present) begin
                  we = 1'b1;
                  if (req.op == OP_WB_DIRTY && !(x && c == 5'd1)) begin
                     err = 1'b1;
                  end
                  if ((b & cbit) == '0) begin
                     err = 1'b1;
                  end
                  if (req.op == OP_WB_DIRTY && req.request_flags[FLAG_KEEP_EXCL]) begin
                     st = CST_E;
                  end else begin
                     b  = b & ~cbit;
                     c  = c - 5'd1;
                     st = CST_I;
                  end
                  if (c == 5'd0) begin
                     b  = '0;
                     x  = 1'b0;
                     ev = 1'b1;
                  end
               end
            end
            OP_FORWARD: begin
               fl = req.is_flush;
               if (!req.entry_present) begin
                  snd = use_mask;
               end else if (c != 5'd0) begin
                  we  = 1'b1;
                  snd = b & use_mask;
                  if (5'($countones(snd)) != c) begin
                     err = 1'b1;
                  end
                  if (!x || c != 5'd1) begin
                     err = 1'b1;
                  end
                  x = 1'b0;
               end
               if (snd != '0) begin
                  kind = KIND_FORWARD;
               end
            end
            OP_CLEAR: begin
               if (req.entry_present) begin
                  we = 1'b1;
                  b  = '0;
                  c  = '0;
                  x  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      upd_we             = we;
      upd_bits           = b;
      upd_count          = c;
      upd_excl           = x;
      rsp.child_state    = st;
      rsp.inval_mask     = 16'(snd);
      rsp.inval_kind     = kind;
      rsp.inval_flush    = fl;
      rsp.evict_entry    = ev;
      rsp.protocol_error = err;
   end

endmodule

// File: rtl/mesi_directory_sharer_tracker.sv
// ----------------------------------------------------------------------------
// mesi_directory_sharer_tracker
// Full bit vector directory: sharer set, count and exclusive mark per entry.
//
// Requests arrive on req_valid/req_ready with a req_type payload; each
// transfer produces exactly one rsp_type result on rsp_valid/rsp_ready.
// csr_wr_en/csr_wr_data set the number of attached children (reset 16);
// write it only while no request is in flight.
// A request is read from the directory memory in the accept cycle (ST_IDLE)
// and modified and written back in ST_EXEC, through the single
// read-modify-write path of that memory. One request is in flight at a
// time, so a new request is taken only after the last one is written back.
// The result is registered at the end of the write-back cycle. A result
// that waits on rsp_ready does not block the next request transfer; that
// request then holds in its write-back cycle until the result register is
// free, and its memory write holds with it.
// After reset all min(ENTRIES, 1024) entries of the memory are swept to zero,
// one entry per cycle; req_ready stays low during the sweep.
// ----------------------------------------------------------------------------
module mesi_directory_sharer_tracker #(
   parameter int CHILDREN = 16,
   parameter int ENTRIES  = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdst_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);
   import mdst_pkg::*;

   localparam int SW    = (CHILDREN < 16) ? CHILDREN : 16;
   localparam int DEPTH = (ENTRIES < 1024) ? ENTRIES : 1024;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = SW + 6;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    csr_ff, csr_in;
   logic [DW-1:0] rd_data_ff;

   logic [DW-1:0] mem [DEPTH];

   logic          exec_go;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] use_mask;
   logic          eng_we;
   logic [SW-1:0] eng_bits;
   logic [4:0]    eng_count;
   logic          eng_excl;
   rsp_type       eng_rsp;

   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < SW; i++) begin
         use_mask[i] = (i < int'(csr_ff));
      end
   end

   mdst_engine #(
      .SW       (SW),
      .CHILDREN (CHILDREN),
      .ENTRIES  (ENTRIES)
   ) u_engine (
      .req       (req_ff),
      .use_mask  (use_mask),
      .cur_bits  (rd_data_ff[DW-1:6]),
      .cur_count (rd_data_ff[5:1]),
      .cur_excl  (rd_data_ff[0]),
      .upd_we    (eng_we),
      .upd_bits  (eng_bits),
      .upd_count (eng_count),
      .upd_excl  (eng_excl),
      .rsp       (eng_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      clr_in    = (state_ff == ST_CLEAR) ? clr_ff + AW'(1) : clr_ff;
      req_in    = (req_valid && req_ready) ? req_data : req_ff;
      rsp_in    = exec_go ? eng_rsp : rsp_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      csr_in    = csr_wr_en ? csr_wr_data : csr_ff;
      rd_addr   = (state_ff == ST_IDLE) ? req_data.entry_index[AW-1:0]
                                        : req_ff.entry_index[AW-1:0];
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = exec_go && eng_we;
         mem_waddr = req_ff.entry_index[AW-1:0];
         mem_wdata = {eng_bits, eng_count, eng_excl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= CHILDREN_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_ff       <= csr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sweep_blocks_requests : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request ready during directory sweep");

   a_accept_enters_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC) && !req_ready)
      else $error("accepted request did not enter write-back");

   a_rsp_from_exec : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EXEC))
      else $error("result raised without a write-back cycle");

   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && eng_we) |-> (int'(req_ff.entry_index) < ENTRIES))
      else $error("directory write for an entry out of range");

endmodule

// File: sim/mdst_checker.sv
// ----------------------------------------------------------------------------
// mdst_checker
// Watches the request, result and register ports of the sharer tracker,
// keeps its own copy of the directory, predicts the result of every request
// transfer and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module mdst_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mdst_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mdst_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   output int                mismatch_count,
   output int                grants_pending
);
   import mdst_pkg::*;

   localparam int NUM_CHILDREN = 16;
   localparam int NUM_ENTRIES  = 1024;

   logic [15:0] dir_sharers [NUM_ENTRIES];
   logic [4:0]  dir_count   [NUM_ENTRIES];
   logic        dir_excl    [NUM_ENTRIES];
   logic [4:0]  children_cfg;
   rsp_type     predicted_grants [$];

   function automatic logic [15:0] reach_mask();
      logic [16:0] m;
      int          n;
      n = (children_cfg > NUM_CHILDREN) ? NUM_CHILDREN : int'(children_cfg);
      m = (17'd1 << n) - 17'd1;
      return m[15:0];
   endfunction

   function automatic rsp_type resolve_request(req_type rq);
      rsp_type     r;
      int          e;
      logic [15:0] cbit;
      logic [15:0] reach;
      logic [15:0] bits;
      logic [4:0]  cnt;
      logic        ex;
      r = '0;
      r.child_state = CST_UNCHANGED;
      e = int'(rq.entry_index);
      cbit = 16'd1 << rq.child_id;
      reach = reach_mask();
      bits = dir_sharers[e];
      cnt = dir_count[e];
      ex = dir_excl[e];
      case (rq.op)
         OP_RD_SHARE: begin
            if (!rq.entry_present) begin
               bits = '0;
               cnt = '0;
               ex = 1'b0;
            end
            if (cnt == 5'd0 && !rq.request_flags[FLAG_NO_EXCL]) begin
               ex = 1'b1;
               bits |= cbit;
               cnt = 5'd1;
               r.child_state = CST_E;
            end else begin
               if ((bits & cbit) != 16'd0) r.protocol_error = 1'b1;
               if (ex && cnt == 5'd1) begin
                  r.inval_mask = bits & reach;
                  if ($countones(r.inval_mask) != int'(cnt)) r.protocol_error = 1'b1;
                  if (r.inval_mask != 16'd0) r.inval_kind = KIND_DOWNGRADE;
               end
               bits |= cbit;
               cnt = cnt + 5'd1;
               ex = 1'b0;
               r.child_state = CST_S;
            end
         end
         OP_RD_EXCL: begin
            if (!rq.entry_present) begin
               bits = '0;
               cnt = '0;
               ex = 1'b0;
            end
            if ((bits & cbit) != 16'd0) begin
               if (ex && cnt == 5'd1) r.protocol_error = 1'b1;
               bits &= ~cbit;
               cnt = cnt - 5'd1;
            end
            if (cnt != 5'd0) begin
               r.inval_mask = bits & reach;
               if ($countones(r.inval_mask) != int'(cnt)) r.protocol_error = 1'b1;
               bits &= ~r.inval_mask;
               cnt = 5'd0;
               if (r.inval_mask != 16'd0) r.inval_kind = KIND_INVAL;
            end
            bits |= cbit;
            cnt = cnt + 5'd1;
            ex = 1'b1;
            if (cnt != 5'd1) r.protocol_error = 1'b1;
            r.child_state = CST_M;
         end
         OP_WB_CLEAN, OP_WB_DIRTY: begin
            if (rq.entry_present) begin
               if (rq.op == OP_WB_DIRTY && !(ex && cnt == 5'd1)) r.protocol_error = 1'b1;
               if ((bits & cbit) == 16'd0) r.protocol_error = 1'b1;
               if (rq.op == OP_WB_DIRTY && rq.request_flags[FLAG_KEEP_EXCL]) begin
                  r.child_state = CST_E;
               end else begin
                  bits &= ~cbit;
                  cnt = cnt - 5'd1;
                  r.child_state = CST_I;
               end
               if (cnt == 5'd0) begin
                  bits = '0;
                  ex = 1'b0;
                  r.evict_entry = 1'b1;
               end
            end
         end
         OP_FORWARD: begin
            r.inval_flush = rq.is_flush;
            if (!rq.entry_present) begin
               r.inval_mask = reach;
            end else if (cnt != 5'd0) begin
               r.inval_mask = bits & reach;
               if ($countones(r.inval_mask) != int'(cnt)) r.protocol_error = 1'b1;
               if (!ex || cnt != 5'd1) r.protocol_error = 1'b1;
               ex = 1'b0;
            end
            if (r.inval_mask != 16'd0) r.inval_kind = KIND_FORWARD;
         end
         OP_CLEAR: begin
            if (rq.entry_present) begin
               bits = '0;
               cnt = '0;
               ex = 1'b0;
            end
         end
         default: begin
         end
      endcase
      dir_sharers[e] = bits;
      dir_count[e] = cnt;
      dir_excl[e] = ex;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            dir_sharers[k] = '0;
            dir_count[k] = '0;
            dir_excl[k] = 1'b0;
         end
         children_cfg = CHILDREN_RESET;
         predicted_grants.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) children_cfg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (predicted_grants.size() == 0) begin
               $display("%0t: result transfer %h with none expected", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_grants.pop_front();
               check_field("child_state", 16'(want.child_state),
                           16'(rsp_data.child_state));
               check_field("inval_mask", want.inval_mask, rsp_data.inval_mask);
               check_field("inval_kind", 16'(want.inval_kind),
                           16'(rsp_data.inval_kind));
               check_field("inval_flush", 16'(want.inval_flush),
                           16'(rsp_data.inval_flush));
               check_field("evict_entry", 16'(want.evict_entry),
                           16'(rsp_data.evict_entry));
               check_field("protocol_error", 16'(want.protocol_error),
                           16'(rsp_data.protocol_error));
            end
         end
         if (req_valid && req_ready) predicted_grants.push_back(resolve_request(req_data));
      end
      grants_pending = predicted_grants.size();
   end

endmodule

// File: sim/tb_mesi_directory_sharer_tracker.sv
// ----------------------------------------------------------------------------
// tb_mesi_directory_sharer_tracker
// Drives directed and random directory requests through the sharer tracker
// under random request gaps and result stalls, steps the child count through
// several settings, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_mesi_directory_sharer_tracker;
   import mdst_pkg::*;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int PHASES       = 6;
   localparam int HOT_LINES    = 8;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   int          mismatch_count;
   int          grants_pending;
   int          cycle_count = 0;
   int          stall_left;
   logic [4:0]  children_now;
   logic [9:0]  hot_index  [HOT_LINES];
   logic [15:0] hot_owners [HOT_LINES];

   mesi_directory_sharer_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   mdst_checker grant_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .grants_pending(grants_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // stall the result side at random, with calm stretches
   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ((cycle_count / 500) % 3 != 0) stall_left = draw_gap();
         end
      end
   end

   function automatic req_type make_request(logic [2:0] op, logic [9:0] idx,
                                            logic present, logic [3:0] child,
                                            logic [1:0] flags, logic flush);
      req_type rq;
      rq.op = op;
      rq.entry_index = idx;
      rq.entry_present = present;
      rq.child_id = child;
      rq.request_flags = flags;
      rq.is_flush = flush;
      return rq;
   endfunction

   // hold the transfer until accepted, then return at the next falling edge
   task automatic send_request(input req_type rq);
      int gap;
      gap = ((cycle_count / 700) % 4 == 0) ? 0 : draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = rq;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (grants_pending != 0) @(negedge clock);
   endtask

   task automatic set_children(input logic [4:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      children_now = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [3:0] pick_child(logic [15:0] pool);
      int start;
      int c;
      if (pool == 16'd0) return 4'($urandom_range(0, 15));
      start = $urandom_range(0, 15);
      for (int k = 0; k < 16; k++) begin
         c = (start + k) % 16;
         if (pool[c]) return 4'(c);
      end
      return 4'd0;
   endfunction

   // mostly well-formed traffic on a few hot lines, some noise elsewhere
   task automatic build_random(output req_type rq, output bit counted);
      int          slot;
      int          r;
      int          lim;
      bit          tracked;
      logic [16:0] reach;
      logic [15:0] owners;
      logic [15:0] cbit;
      slot = $urandom_range(0, HOT_LINES - 1);
      tracked = ($urandom_range(0, 99) < 90);
      lim = (children_now > 16) ? 16 : int'(children_now);
      if (lim == 0) lim = 16;
      reach = (17'd1 << lim) - 17'd1;
      owners = tracked ? hot_owners[slot] : 16'd0;
      r = $urandom_range(0, 99);
      if (r < 30) rq.op = OP_RD_SHARE;
      else if (r < 45) rq.op = OP_RD_EXCL;
      else if (r < 64) rq.op = OP_WB_CLEAN;
      else if (r < 77) rq.op = OP_WB_DIRTY;
      else if (r < 89) rq.op = OP_FORWARD;
      else if (r < 97) rq.op = OP_CLEAR;
      else rq.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      rq.entry_index = tracked ? hot_index[slot] : 10'($urandom_range(0, 1023));
      rq.entry_present = (owners != 16'd0) ? ($urandom_range(0, 99) < 95)
                                           : ($urandom_range(0, 99) < 75);
      if ($urandom_range(0, 99) < 15)
         rq.child_id = 4'($urandom_range(0, 15));
      else if (rq.op == OP_WB_CLEAN || rq.op == OP_WB_DIRTY)
         rq.child_id = pick_child(owners);
      else
         rq.child_id = pick_child(~owners & reach[15:0]);
      rq.request_flags[FLAG_NO_EXCL] = ($urandom_range(0, 99) < 25);
      rq.request_flags[FLAG_KEEP_EXCL] = ($urandom_range(0, 99) < 50);
      rq.is_flush = 1'($urandom_range(0, 1));
      counted = (rq.op <= OP_CLEAR);
      if (tracked) begin
         cbit = 16'd1 << rq.child_id;
         case (rq.op)
            OP_RD_SHARE: begin
               if (!rq.entry_present) owners = 16'd0;
               owners |= cbit;
            end
            OP_RD_EXCL: begin
               owners = cbit;
            end
            OP_WB_CLEAN, OP_WB_DIRTY: begin
               if (rq.entry_present &&
                   !(rq.op == OP_WB_DIRTY && rq.request_flags[FLAG_KEEP_EXCL]))
                  owners &= ~cbit;
            end
            OP_CLEAR: begin
               if (rq.entry_present) owners = 16'd0;
            end
            default: begin
            end
         endcase
         hot_owners[slot] = owners;
      end
   endtask

   initial begin
      req_type     rq;
      bit          counted;
      int          done;
      logic [4:0]  children_plan [PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      children_now = CHILDREN_RESET;
      children_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'($urandom_range(2, 15))};
      hot_index = '{10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1022};
      for (int k = 2; k < 6; k++) hot_index[k] = 10'($urandom_range(2, 1021));
      for (int k = 0; k < HOT_LINES; k++) begin
         hot_owners[k] = 16'd0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_children(CHILDREN_RESET);

      send_request(make_request(OP_RD_SHARE, 10'd0, 1'b0, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_RD_SHARE, 10'd0, 1'b1, 4'd15, 2'b00, 1'b1));
      send_request(make_request(OP_RD_SHARE, 10'd0, 1'b1, 4'd15, 2'b00, 1'b0));
      send_request(make_request(OP_RD_EXCL, 10'd0, 1'b1, 4'd3, 2'b10, 1'b0));
      send_request(make_request(OP_WB_DIRTY, 10'd0, 1'b1, 4'd3, 2'b10, 1'b0));
      send_request(make_request(OP_WB_DIRTY, 10'd0, 1'b1, 4'd3, 2'b00, 1'b0));
      send_request(make_request(OP_WB_CLEAN, 10'd0, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_FORWARD, 10'd0, 1'b1, 4'd0, 2'b00, 1'b1));
      send_request(make_request(OP_CLEAR, 10'd0, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_WB_CLEAN, 10'd5, 1'b0, 4'd7, 2'b11, 1'b1));
      send_request(make_request(OP_FORWARD, 10'd5, 1'b0, 4'd7, 2'b00, 1'b0));
      send_request(make_request(OP_FORWARD, 10'd1023, 1'b0, 4'd15, 2'b11, 1'b1));
      send_request(make_request(OP_SPARE_6, 10'd1023, 1'b1, 4'd15, 2'b11, 1'b1));
      send_request(make_request(OP_SPARE_7, 10'd1023, 1'b1, 4'd15, 2'b11, 1'b1));
      send_request(make_request(OP_RD_SHARE, 10'd1023, 1'b1, 4'd15, 2'b01, 1'b0));
      send_request(make_request(OP_RD_EXCL, 10'd1023, 1'b1, 4'd15, 2'b00, 1'b0));
      send_request(make_request(OP_RD_EXCL, 10'd1023, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_RD_SHARE, 10'd1023, 1'b1, 4'd0, 2'b11, 1'b0));
      send_request(make_request(OP_FORWARD, 10'd1023, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_CLEAR, 10'd1023, 1'b0, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_WB_DIRTY, 10'd1023, 1'b0, 4'd0, 2'b10, 1'b0));
      send_request(make_request(OP_WB_DIRTY, 10'd1023, 1'b1, 4'd0, 2'b10, 1'b0));
      send_request(make_request(OP_WB_CLEAN, 10'd1023, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_CLEAR, 10'd1023, 1'b1, 4'd0, 2'b00, 1'b0));
      send_request(make_request(OP_CLEAR, 10'd0, 1'b1, 4'd0, 2'b00, 1'b0));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_children(children_plan[p]);
         done = 0;
         while (done < RANDOM_ITEMS / PHASES) begin
            build_random(rq, counted);
            send_request(rq);
            if (counted) done++;
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
